/* rtl/btu_pkg.sv */
// ============================================================================
// btu_pkg
// Shared types and constants for the bilinear texture upsampler.
// ============================================================================
`default_nettype none

package btu_pkg;

    // Source texture limits
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int COORD_W        = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W          = $clog2(MAX_SRC_HEIGHT);
    localparam int DIM_W          = 9;

    // Texel store: row-major, split into even/odd banks by address bit 0
    localparam int TEXEL_ADDR_W = 16;
    localparam int TEXEL_W      = 32;
    localparam int BANK_ADDR_W  = TEXEL_ADDR_W - 1;
    localparam int BANK_DEPTH   = 1 << BANK_ADDR_W;

    // Channel and interpolation arithmetic
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 4;
    localparam int FRAC_BITS = 8;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int HBL_W     = CHAN_W + FRAC_BITS;
    localparam int VBL_W     = CHAN_W + 2 * FRAC_BITS;

    // Position arithmetic: out (12 bits) times step (unsigned Q9.16)
    localparam int OUT_W    = 12;
    localparam int STEP_W   = 25;
    localparam int POS_FRAC = 16;
    localparam int PROD_W   = OUT_W + STEP_W;
    localparam int IP_W     = PROD_W - POS_FRAC;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_STEP_X     = 2'd2,
        CFG_STEP_Y     = 2'd3
    } cfg_index_t;

    // Write request into the texel store
    typedef struct packed {
        logic                    en;
        logic [TEXEL_ADDR_W-1:0] addr;
        logic [TEXEL_W-1:0]      data;
    } wr_req_t;

    // Read request: linear addresses of the left texel of the top and bottom rows
    typedef struct packed {
        logic                    en;
        logic [TEXEL_ADDR_W-1:0] addr_top;
        logic [TEXEL_ADDR_W-1:0] addr_bot;
    } rd_req_t;

    // Registered read data, one word per bank and row
    typedef struct packed {
        logic [TEXEL_W-1:0] top_even;
        logic [TEXEL_W-1:0] top_odd;
        logic [TEXEL_W-1:0] bot_even;
        logic [TEXEL_W-1:0] bot_odd;
    } rd_data_t;

    // One axis after locate and clamp
    typedef struct packed {
        logic [COORD_W-1:0]   base;
        logic                 step;
        logic [FRAC_BITS-1:0] frac;
    } axis_t;

endpackage

`default_nettype wire

/* rtl/btu_texel_store.sv */
// ============================================================================
// btu_texel_store
// Even/odd banked texel memory: one write and two reads per bank per cycle.
// ============================================================================
`default_nettype none

module btu_texel_store (
    input  wire logic              clk,
    input  wire btu_pkg::wr_req_t  wr,
    input  wire btu_pkg::rd_req_t  rd,
    output btu_pkg::rd_data_t      rd_data
);

    logic [btu_pkg::TEXEL_W-1:0] bank_even [btu_pkg::BANK_DEPTH];
    logic [btu_pkg::TEXEL_W-1:0] bank_odd  [btu_pkg::BANK_DEPTH];

    logic [btu_pkg::TEXEL_ADDR_W:0]  top_inc;
    logic [btu_pkg::TEXEL_ADDR_W:0]  bot_inc;
    logic [btu_pkg::BANK_ADDR_W-1:0] top_even_addr;
    logic [btu_pkg::BANK_ADDR_W-1:0] top_odd_addr;
    logic [btu_pkg::BANK_ADDR_W-1:0] bot_even_addr;
    logic [btu_pkg::BANK_ADDR_W-1:0] bot_odd_addr;
    logic [btu_pkg::BANK_ADDR_W-1:0] wr_bank_addr;

    btu_pkg::rd_data_t rd_data_reg;

    // Pair {A, A+1}: even word sits at (A+1)/2, odd word at A/2
    assign top_inc       = {1'b0, rd.addr_top} + 1'b1;
    assign bot_inc       = {1'b0, rd.addr_bot} + 1'b1;
    assign top_even_addr = top_inc[btu_pkg::BANK_ADDR_W:1];
    assign bot_even_addr = bot_inc[btu_pkg::BANK_ADDR_W:1];
    assign top_odd_addr  = rd.addr_top[btu_pkg::TEXEL_ADDR_W-1:1];
    assign bot_odd_addr  = rd.addr_bot[btu_pkg::TEXEL_ADDR_W-1:1];
    assign wr_bank_addr  = wr.addr[btu_pkg::TEXEL_ADDR_W-1:1];

    // Even bank
    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.addr[0])
        begin
            bank_even[wr_bank_addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg.top_even <= bank_even[top_even_addr];
            rd_data_reg.bot_even <= bank_even[bot_even_addr];
        end
    end

    // Odd bank
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.addr[0])
        begin
            bank_odd[wr_bank_addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg.top_odd <= bank_odd[top_odd_addr];
            rd_data_reg.bot_odd <= bank_odd[bot_odd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/bilinear_texture_upsampler_core.sv */
// ============================================================================
// bilinear_texture_upsampler_core
// RGBA8 bilinear scaler: stores a source texture and samples output pixels.
// ============================================================================
// A sample word is accepted into stage 1 and its result is registered
//   in stage 6 (six pipeline stages, the texel read registered in stage 4).
// Throughput: one word per cycle while in_stall is low, writes and samples alike; writes give no result.
// Each stage advances on its own, so bubbles fill while the output is stalled.
// Reset clears the stage valid bits and loads the register defaults
//   (256 x 256 texels, unit steps); texel memory contents are not cleared.
`default_nettype none

module bilinear_texture_upsampler_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port
    input  wire logic                               cfg_write,
    input  wire logic [btu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [btu_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               opcode,
    input  wire logic [btu_pkg::TEXEL_ADDR_W-1:0]   texel_address,
    input  wire logic [btu_pkg::TEXEL_W-1:0]        texel_data,
    input  wire logic [btu_pkg::OUT_W-1:0]          out_x,
    input  wire logic [btu_pkg::OUT_W-1:0]          out_y,
    // Output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [btu_pkg::CHAN_W-1:0]              red,
    output logic [btu_pkg::CHAN_W-1:0]              green,
    output logic [btu_pkg::CHAN_W-1:0]              blue,
    output logic [btu_pkg::CHAN_W-1:0]              alpha
);

    localparam logic [btu_pkg::DIM_W-1:0] MAX_W = btu_pkg::DIM_W'(btu_pkg::MAX_SRC_WIDTH);
    localparam logic [btu_pkg::DIM_W-1:0] MAX_H = btu_pkg::DIM_W'(btu_pkg::MAX_SRC_HEIGHT);
    localparam logic [btu_pkg::PROD_W-1:0] HALF = btu_pkg::PROD_W'(1 << (btu_pkg::POS_FRAC - 1));
    localparam logic [btu_pkg::WGT_W-1:0] ONE_W = btu_pkg::WGT_W'(1 << btu_pkg::FRAC_BITS);

    // Zero acts as one, values above the maximum saturate
    function automatic logic [btu_pkg::DIM_W-1:0] eff_dim(
        input logic [btu_pkg::DIM_W-1:0] v,
        input logic [btu_pkg::DIM_W-1:0] maxv
    );
        logic [btu_pkg::DIM_W-1:0] r;
        if (v == '0)
            r = btu_pkg::DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    // Split out*step - 0.5 into floor and fraction, then clamp the neighbor pair
    function automatic btu_pkg::axis_t locate(
        input logic [btu_pkg::PROD_W-1:0]  prod,
        input logic [btu_pkg::COORD_W-1:0] lim
    );
        logic [btu_pkg::PROD_W-1:0] diff;
        logic [btu_pkg::IP_W-1:0]   ip;
        logic                       neg;
        btu_pkg::axis_t             r;
        diff   = prod - HALF;
        ip     = diff[btu_pkg::PROD_W-1:btu_pkg::POS_FRAC];
        neg    = prod < HALF;
        r.frac = diff[btu_pkg::POS_FRAC-1 -: btu_pkg::FRAC_BITS];
        r.step = !neg && (ip < btu_pkg::IP_W'(lim));
        if (neg)
            r.base = '0;
        else if (r.step)
            r.base = ip[btu_pkg::COORD_W-1:0];
        else
            r.base = lim;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers (held as effective dimensions)
    // ------------------------------------------------------------------
    logic [btu_pkg::DIM_W-1:0]  width_reg;
    logic [btu_pkg::DIM_W-1:0]  height_reg;
    logic [btu_pkg::STEP_W-1:0] step_x_reg;
    logic [btu_pkg::STEP_W-1:0] step_y_reg;
    logic [btu_pkg::COORD_W-1:0] width_lim;
    logic [btu_pkg::ROW_W-1:0]   height_lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= MAX_W;
            height_reg <= MAX_H;
            step_x_reg <= btu_pkg::STEP_W'(1 << btu_pkg::POS_FRAC);
            step_y_reg <= btu_pkg::STEP_W'(1 << btu_pkg::POS_FRAC);
        end
        else if (cfg_write)
        begin
            unique case (btu_pkg::cfg_index_t'(cfg_index))
                btu_pkg::CFG_SRC_WIDTH:
                    width_reg <= eff_dim(cfg_data[btu_pkg::DIM_W-1:0], MAX_W);
                btu_pkg::CFG_SRC_HEIGHT:
                    height_reg <= eff_dim(cfg_data[btu_pkg::DIM_W-1:0], MAX_H);
                btu_pkg::CFG_STEP_X:
                    step_x_reg <= cfg_data[btu_pkg::STEP_W-1:0];
                btu_pkg::CFG_STEP_Y:
                    step_y_reg <= cfg_data[btu_pkg::STEP_W-1:0];
            endcase
        end
    end

    assign width_lim  = btu_pkg::COORD_W'(width_reg - 1'b1);
    assign height_lim = btu_pkg::ROW_W'(height_reg - 1'b1);

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its content moves on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !s6_valid_reg || !out_stall;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign in_stall = !en1;

    // ------------------------------------------------------------------
    // Stage 1: capture word, position products
    // ------------------------------------------------------------------
    btu_pkg::opcode_t                s1_opcode_reg;
    logic [btu_pkg::TEXEL_ADDR_W-1:0] s1_addr_reg;
    logic [btu_pkg::TEXEL_W-1:0]      s1_data_reg;
    logic [btu_pkg::PROD_W-1:0]       s1_prod_x_reg;
    logic [btu_pkg::PROD_W-1:0]       s1_prod_y_reg;
    logic [btu_pkg::PROD_W-1:0]       s1_prod_x_next;
    logic [btu_pkg::PROD_W-1:0]       s1_prod_y_next;

    assign s1_prod_x_next = btu_pkg::PROD_W'(out_x) * btu_pkg::PROD_W'(step_x_reg);
    assign s1_prod_y_next = btu_pkg::PROD_W'(out_y) * btu_pkg::PROD_W'(step_y_reg);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_opcode_reg <= btu_pkg::opcode_t'(opcode);
            s1_addr_reg   <= texel_address;
            s1_data_reg   <= texel_data;
            s1_prod_x_reg <= s1_prod_x_next;
            s1_prod_y_reg <= s1_prod_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: floor, fraction, edge clamp
    // ------------------------------------------------------------------
    btu_pkg::opcode_t                 s2_opcode_reg;
    logic [btu_pkg::TEXEL_ADDR_W-1:0] s2_addr_reg;
    logic [btu_pkg::TEXEL_W-1:0]      s2_data_reg;
    btu_pkg::axis_t                   s2_x_reg;
    btu_pkg::axis_t                   s2_y_reg;
    btu_pkg::axis_t                   s2_x_next;
    btu_pkg::axis_t                   s2_y_next;

    assign s2_x_next = locate(s1_prod_x_reg, width_lim);
    assign s2_y_next = locate(s1_prod_y_reg, btu_pkg::COORD_W'(height_lim));

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_opcode_reg <= s1_opcode_reg;
            s2_addr_reg   <= s1_addr_reg;
            s2_data_reg   <= s1_data_reg;
            s2_x_reg      <= s2_x_next;
            s2_y_reg      <= s2_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: row-major addresses of the top and bottom left texels
    // ------------------------------------------------------------------
    btu_pkg::opcode_t                 s3_opcode_reg;
    logic [btu_pkg::TEXEL_ADDR_W-1:0] s3_addr_reg;
    logic [btu_pkg::TEXEL_W-1:0]      s3_data_reg;
    logic [btu_pkg::TEXEL_ADDR_W-1:0] s3_addr_top_reg;
    logic [btu_pkg::TEXEL_ADDR_W-1:0] s3_addr_bot_reg;
    logic                             s3_dx_reg;
    logic [btu_pkg::FRAC_BITS-1:0]    s3_fx_reg;
    logic [btu_pkg::FRAC_BITS-1:0]    s3_fy_reg;
    logic [btu_pkg::ROW_W-1:0]        y1;
    logic [btu_pkg::ROW_W+btu_pkg::DIM_W-1:0] row_top;
    logic [btu_pkg::ROW_W+btu_pkg::DIM_W-1:0] row_bot;
    logic [btu_pkg::TEXEL_ADDR_W-1:0] s3_addr_top_next;
    logic [btu_pkg::TEXEL_ADDR_W-1:0] s3_addr_bot_next;

    assign y1      = btu_pkg::ROW_W'(s2_y_reg.base) + btu_pkg::ROW_W'(s2_y_reg.step);
    assign row_top = btu_pkg::ROW_W'(s2_y_reg.base) * width_reg;
    assign row_bot = y1 * width_reg;
    assign s3_addr_top_next = btu_pkg::TEXEL_ADDR_W'(row_top + btu_pkg::ROW_W'(s2_x_reg.base));
    assign s3_addr_bot_next = btu_pkg::TEXEL_ADDR_W'(row_bot + btu_pkg::ROW_W'(s2_x_reg.base));

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_opcode_reg   <= s2_opcode_reg;
            s3_addr_reg     <= s2_addr_reg;
            s3_data_reg     <= s2_data_reg;
            s3_addr_top_reg <= s3_addr_top_next;
            s3_addr_bot_reg <= s3_addr_bot_next;
            s3_dx_reg       <= s2_x_reg.step;
            s3_fx_reg       <= s2_x_reg.frac;
            s3_fy_reg       <= s2_y_reg.frac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: texel store access (writes retire here, reads registered)
    // ------------------------------------------------------------------
    btu_pkg::wr_req_t  wr_req;
    btu_pkg::rd_req_t  rd_req;
    btu_pkg::rd_data_t rd_data;

    assign wr_req.en       = s3_valid_reg && en4 && (s3_opcode_reg == btu_pkg::OP_WRITE);
    assign wr_req.addr     = s3_addr_reg;
    assign wr_req.data     = s3_data_reg;
    assign rd_req.en       = en4;
    assign rd_req.addr_top = s3_addr_top_reg;
    assign rd_req.addr_bot = s3_addr_bot_reg;

    btu_texel_store u_store (
        .clk     (clk),
        .wr      (wr_req),
        .rd      (rd_req),
        .rd_data (rd_data)
    );

    logic                          s4_top_odd_reg;
    logic                          s4_bot_odd_reg;
    logic                          s4_dx_reg;
    logic [btu_pkg::FRAC_BITS-1:0] s4_fx_reg;
    logic [btu_pkg::FRAC_BITS-1:0] s4_fy_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_top_odd_reg <= s3_addr_top_reg[0];
            s4_bot_odd_reg <= s3_addr_bot_reg[0];
            s4_dx_reg      <= s3_dx_reg;
            s4_fx_reg      <= s3_fx_reg;
            s4_fy_reg      <= s3_fy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: pick the four texels, horizontal blend per channel
    // ------------------------------------------------------------------
    logic [btu_pkg::TEXEL_W-1:0] tl, tr, bl, br;
    logic [btu_pkg::WGT_W-1:0]   wx0, wx1;
    logic [btu_pkg::HBL_W-1:0]   s5_top_reg  [btu_pkg::NUM_CHAN];
    logic [btu_pkg::HBL_W-1:0]   s5_bot_reg  [btu_pkg::NUM_CHAN];
    logic [btu_pkg::HBL_W-1:0]   s5_top_next [btu_pkg::NUM_CHAN];
    logic [btu_pkg::HBL_W-1:0]   s5_bot_next [btu_pkg::NUM_CHAN];
    logic [btu_pkg::FRAC_BITS-1:0] s5_fy_reg;

    always_comb
    begin
        tl = s4_top_odd_reg ? rd_data.top_odd : rd_data.top_even;
        bl = s4_bot_odd_reg ? rd_data.bot_odd : rd_data.bot_even;
        if (s4_dx_reg)
        begin
            tr = s4_top_odd_reg ? rd_data.top_even : rd_data.top_odd;
            br = s4_bot_odd_reg ? rd_data.bot_even : rd_data.bot_odd;
        end
        else
        begin
            tr = tl;
            br = bl;
        end
    end

    assign wx1 = btu_pkg::WGT_W'(s4_fx_reg);
    assign wx0 = ONE_W - wx1;

    always_comb
    begin
        for (int c = 0; c < btu_pkg::NUM_CHAN; c++)
        begin
            s5_top_next[c] = btu_pkg::HBL_W'(
                btu_pkg::HBL_W'(tl[c*btu_pkg::CHAN_W +: btu_pkg::CHAN_W]) * btu_pkg::HBL_W'(wx0)
              + btu_pkg::HBL_W'(tr[c*btu_pkg::CHAN_W +: btu_pkg::CHAN_W]) * btu_pkg::HBL_W'(wx1));
            s5_bot_next[c] = btu_pkg::HBL_W'(
                btu_pkg::HBL_W'(bl[c*btu_pkg::CHAN_W +: btu_pkg::CHAN_W]) * btu_pkg::HBL_W'(wx0)
              + btu_pkg::HBL_W'(br[c*btu_pkg::CHAN_W +: btu_pkg::CHAN_W]) * btu_pkg::HBL_W'(wx1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_top_reg <= s5_top_next;
            s5_bot_reg <= s5_bot_next;
            s5_fy_reg  <= s4_fy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: vertical blend, floor, output register
    // ------------------------------------------------------------------
    logic [btu_pkg::WGT_W-1:0]  wy0, wy1;
    logic [btu_pkg::VBL_W-1:0]  v_sum [btu_pkg::NUM_CHAN];
    logic [btu_pkg::CHAN_W-1:0] s6_chan_reg  [btu_pkg::NUM_CHAN];
    logic [btu_pkg::CHAN_W-1:0] s6_chan_next [btu_pkg::NUM_CHAN];

    assign wy1 = btu_pkg::WGT_W'(s5_fy_reg);
    assign wy0 = ONE_W - wy1;

    always_comb
    begin
        for (int c = 0; c < btu_pkg::NUM_CHAN; c++)
        begin
            v_sum[c] = btu_pkg::VBL_W'(s5_top_reg[c]) * btu_pkg::VBL_W'(wy0)
                     + btu_pkg::VBL_W'(s5_bot_reg[c]) * btu_pkg::VBL_W'(wy1);
            s6_chan_next[c] = v_sum[c][2*btu_pkg::FRAC_BITS +: btu_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_chan_reg <= s6_chan_next;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits; writes drop out after the store stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg && (s3_opcode_reg == btu_pkg::OP_SAMPLE);
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
        end
    end

    assign out_valid = s6_valid_reg;
    assign red       = s6_chan_reg[0];
    assign green     = s6_chan_reg[1];
    assign blue      = s6_chan_reg[2];
    assign alpha     = s6_chan_reg[3];

endmodule

`default_nettype wire
